/* hw/rtl/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int unsigned MAX_RUN = 6;
  localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);

  typedef struct packed {
    logic [7:0] code_unit;
    logic       last_in_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
  } out_word_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_UPPA   = 8'h41;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_TAB = 8'h09;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_CR  = 8'h0D;

  // uppercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = CH_UPPA + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/json_string_escaper_core.sv */
// ----------------------------------------------------------------------------
// json_string_escaper_core
// JSON string escaper: one input byte in, its escaped form out a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Each input word (one byte plus a last-in-string flag) is captured in an
// input register, expanded in one pass into a run of one to six bytes, and
// loaded into an output shift register that sends one byte per cycle while
// out_stall is low, with run_end set on the run's final byte. The next word
// loads as the last byte of a run is taken, so plain bytes flow at one word
// per cycle when the output does not stall; an escape holds the input until
// its run is sent. A byte passes the input register, then the shift register.
module json_string_escaper_core
  import jse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic             in_vld_r;
  in_word_t         in_r;
  logic             start_r;
  logic [7:0]       buf_r [MAX_RUN];
  logic [RUN_W-1:0] len_r;

  logic [7:0]       buf_nxt [MAX_RUN];
  logic [RUN_W-1:0] len_nxt;
  logic             out_take;
  logic             last_byte;
  logic             load_out;
  logic             in_take;
  logic             quote_esc;
  logic [7:0]       c;

  assign last_byte = (len_r == RUN_W'(1));
  assign out_take  = out_valid && !out_stall;
  assign load_out  = in_vld_r && ((len_r == '0) || (last_byte && !out_stall));
  assign in_stall  = in_vld_r && !load_out;
  assign in_take   = in_valid && !in_stall;

  assign out_valid         = (len_r != '0);
  assign out_data.out_char = buf_r[0];
  assign out_data.run_end  = last_byte;

  // expansion of the held byte
  assign c         = in_r.code_unit;
  assign quote_esc = !start_r && !in_r.last_in_string;

  always_comb begin
    for (int i = 0; i < MAX_RUN; i++) begin
      buf_nxt[i] = CH_ZERO;
    end
    buf_nxt[0] = c;
    len_nxt    = RUN_W'(1);
    case (c) inside
      [8'h20:8'h21], [8'h23:8'h2E], [8'h30:8'h5B], [8'h5D:8'hFF]: begin
        buf_nxt[0] = c;
        len_nxt    = RUN_W'(1);
      end
      CC_BS, CC_FF, CC_LF, CC_CR, CC_TAB, CH_SLASH, CH_BSLASH: begin
        buf_nxt[0] = CH_BSLASH;
        len_nxt    = RUN_W'(2);
        case (c)
          CC_BS:   buf_nxt[1] = CH_B;
          CC_FF:   buf_nxt[1] = CH_F;
          CC_LF:   buf_nxt[1] = CH_N;
          CC_CR:   buf_nxt[1] = CH_R;
          CC_TAB:  buf_nxt[1] = CH_T;
          default: buf_nxt[1] = c;  // slash and backslash escape as themselves
        endcase
      end
      CH_QUOTE: begin
        // quote at either end of a string goes out bare
        if (quote_esc) begin
          buf_nxt[0] = CH_BSLASH;
          buf_nxt[1] = CH_QUOTE;
          len_nxt    = RUN_W'(2);
        end
      end
      default: begin
        buf_nxt[0] = CH_BSLASH;
        buf_nxt[1] = CH_U;
        buf_nxt[4] = hex_char(c[7:4]);
        buf_nxt[5] = hex_char(c[3:0]);
        len_nxt    = RUN_W'(MAX_RUN);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      start_r  <= 1'b1;
      len_r    <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (load_out) begin
        in_vld_r <= 1'b0;
      end
      if (load_out) begin
        start_r <= in_r.last_in_string;
        len_r   <= len_nxt;
      end else if (out_take) begin
        len_r <= len_r - RUN_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (load_out) begin
      for (int i = 0; i < MAX_RUN; i++) begin
        buf_r[i] <= buf_nxt[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < MAX_RUN - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

/* hw/rtl/jse_checker.sv */
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks on the escaper's handshakes and runs, bound to the core.
// ----------------------------------------------------------------------------
module jse_checker
  import jse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled input word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input word changed");

  // a stalled output word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // nothing comes out straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a run that has not ended carries on in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_end |=> out_valid)
    else $error("escape run broken off");

  // only escape prefix bytes and the high hex digit can precede a run's end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |->
      (out_data.out_char == CH_BSLASH) || (out_data.out_char == CH_U) ||
      (out_data.out_char == CH_ZERO) || (out_data.out_char == CH_ONE))
    else $error("unexpected byte inside escape run");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for json_string_escaper_core: JSON escaping of a byte stream.
// ----------------------------------------------------------------------------
// Input words go in through the valid/stall handshake. Each accepted word is
// expanded by a local model of the escaper (or a directed literal) into the
// run of bytes that should come out; each output word is checked in order
// against that run. A short table of directed words comes first, then random
// strings. Both sides idle at random outside a calm stretch. Once, the output
// side holds off for a long stretch so that the block fills up and stalls its input.
module tb_top;
  import jse_pkg::*;

  localparam int IDLE_PCT       = 36;
  localparam int RAND_WORDS     = 456;
  localparam int PRESSURE_AT    = 200;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CALM_FROM      = 60;
  localparam int CALM_TO        = 160;

  localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

  // n_lit == 0: expected run comes from the model, else from lit (first byte
  // in the top byte)
  typedef struct packed {
    logic [7:0]  code;
    logic        last;
    logic [2:0]  n_lit;
    logic [47:0] lit;
  } stim_row_t;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  json_string_escaper_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic       string_head = 1'b1;
  int         run_len;
  logic [7:0] run_text [6];
  out_word_t  escaped_text [$];
  out_word_t  want;
  stim_row_t  stim_rows [$];
  int         mismatches = 0;
  int         words_sent = 0;
  bit         calm = 1'b0;
  bit         pressure_done = 1'b0;
  int         hold_left = 0;
  int         stuck = 0;

  function automatic void put_pair(input logic [7:0] e);
    run_len     = 2;
    run_text[0] = CH_BSLASH;
    run_text[1] = e;
  endfunction

  // Escaped run for one byte; also tracks whether the next byte opens a string
  function automatic void escape_byte(input logic [7:0] c, input logic last);
    run_len     = 1;
    run_text[0] = c;
    case (c)
      CC_BS:     put_pair(CH_B);
      CC_FF:     put_pair(CH_F);
      CC_LF:     put_pair(CH_N);
      CC_CR:     put_pair(CH_R);
      CC_TAB:    put_pair(CH_T);
      CH_SLASH:  put_pair(CH_SLASH);
      CH_BSLASH: put_pair(CH_BSLASH);
      CH_QUOTE: begin
        // only a quote inside the string is escaped
        if (!string_head && !last) put_pair(CH_QUOTE);
      end
      default: begin
        if (c < 8'h20) begin
          run_len     = 6;
          run_text[0] = CH_BSLASH;
          run_text[1] = CH_U;
          run_text[2] = CH_ZERO;
          run_text[3] = CH_ZERO;
          run_text[4] = HEX_DIGITS[8 * (15 - c[7:4]) +: 8];
          run_text[5] = HEX_DIGITS[8 * (15 - c[3:0]) +: 8];
        end
      end
    endcase
    string_head = last;
  endfunction

  function automatic void add_row(input logic [7:0] code, input logic last,
                                  input logic [2:0] n_lit, input logic [47:0] lit);
    stim_row_t r;
    r.code  = code;
    r.last  = last;
    r.n_lit = n_lit;
    r.lit   = lit;
    stim_rows = {stim_rows, r};
  endfunction

  function automatic logic [7:0] pick_byte();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 30) b = 8'($urandom_range(31));
    else if (r < 45) b = CH_QUOTE;
    else if (r < 52) b = CH_BSLASH;
    else if (r < 57) b = CH_SLASH;
    else if (r < 61) b = 8'h7F;
    else b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("mismatch @%0t: %s: got %02h, expected %02h", $time, what, got, exp_val);
    mismatches++;
  endtask

  task automatic send_word(input logic [7:0] code, input logic last,
                           input logic [2:0] n_lit, input logic [47:0] lit);
    in_word_t  w;
    out_word_t o;
    int        k;
    w.code_unit      = code;
    w.last_in_string = last;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    escape_byte(code, last);
    if (n_lit != 0) begin
      run_len = int'(n_lit);
      for (k = 0; k < run_len; k++) run_text[k] = lit[47 - 8 * k -: 8];
    end
    for (k = 0; k < run_len; k++) begin
      o.out_char = run_text[k];
      o.run_end  = (k == run_len - 1);
      escaped_text = {escaped_text, o};
    end
  endtask

  initial begin
    int         n;
    int         len;
    int         i;
    bit         broken;
    logic       last;

    // quotes at the head, middle and tail of a string, and a one-byte string
    add_row(CH_QUOTE,  1'b0, 3'd1, {CH_QUOTE, 40'h0});
    add_row(CH_QUOTE,  1'b0, 3'd2, {CH_BSLASH, CH_QUOTE, 32'h0});
    add_row(CH_QUOTE,  1'b1, 3'd1, {CH_QUOTE, 40'h0});
    add_row(CH_QUOTE,  1'b1, 3'd1, {CH_QUOTE, 40'h0});
    add_row(8'h00,     1'b0, 3'd6, {CH_BSLASH, CH_U, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO});
    add_row(8'hFF,     1'b0, 3'd1, {8'hFF, 40'h0});
    add_row(CC_BS,     1'b0, 3'd2, {CH_BSLASH, CH_B, 32'h0});
    add_row(CC_FF,     1'b0, 3'd2, {CH_BSLASH, CH_F, 32'h0});
    add_row(CC_LF,     1'b0, 3'd2, {CH_BSLASH, CH_N, 32'h0});
    add_row(CC_CR,     1'b0, 3'd2, {CH_BSLASH, CH_R, 32'h0});
    add_row(CC_TAB,    1'b0, 3'd2, {CH_BSLASH, CH_T, 32'h0});
    add_row(CH_SLASH,  1'b0, 3'd2, {CH_BSLASH, CH_SLASH, 32'h0});
    add_row(CH_BSLASH, 1'b0, 3'd2, {CH_BSLASH, CH_BSLASH, 32'h0});
    add_row(8'h1F, 1'b0, 3'd0, 48'h0);
    add_row(8'h7F, 1'b0, 3'd0, 48'h0);   // delete passes through
    add_row(8'h20, 1'b0, 3'd0, 48'h0);
    add_row(8'h21, 1'b0, 3'd0, 48'h0);
    add_row(8'h23, 1'b0, 3'd0, 48'h0);
    add_row(8'h2E, 1'b0, 3'd0, 48'h0);
    add_row(8'h30, 1'b0, 3'd0, 48'h0);
    add_row(8'h5B, 1'b0, 3'd0, 48'h0);
    add_row(8'h5D, 1'b0, 3'd0, 48'h0);
    add_row(8'h1A, 1'b1, 3'd0, 48'h0);
    add_row(8'h00, 1'b1, 3'd0, 48'h0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[j])
      send_word(stim_rows[j].code, stim_rows[j].last, stim_rows[j].n_lit, stim_rows[j].lit);

    // random strings; a few carry scrambled last flags
    n = 0;
    while (n < RAND_WORDS) begin
      len    = $urandom_range(1, 8);
      broken = ($urandom_range(99) < 8);
      for (i = 0; i < len && n < RAND_WORDS; i++) begin
        calm = (n >= CALM_FROM && n < CALM_TO);
        last = broken ? 1'($urandom_range(1)) : (i == len - 1);
        send_word(pick_byte(), last, 3'd0, 48'h0);
        n++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (escaped_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // output side: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!pressure_done && words_sent >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left     = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (escaped_text.size() == 0) begin
        report_mismatch("word with nothing expected", out_data.out_char, 8'h00);
      end else begin
        want = escaped_text.pop_front();
        if (out_data.out_char !== want.out_char)
          report_mismatch("out_char", out_data.out_char, want.out_char);
        if (out_data.run_end !== want.run_end)
          report_mismatch("run_end", {7'd0, out_data.run_end}, {7'd0, want.run_end});
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= WATCHDOG_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

endmodule

/* sim.f */
hw/rtl/jse_pkg.sv
hw/rtl/json_string_escaper_core.sv
hw/rtl/jse_checker.sv
sim/tb_top.sv
